FILE: sv/x86_mov_instruction_decoder_core_assert.svh
// Assertion macros shared by the MOV decoder RTL.
// Needs clk and arst_n in the scope of the module that uses them.
`ifndef X86_MOV_INSTRUCTION_DECODER_CORE_ASSERT_SVH
`define X86_MOV_INSTRUCTION_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define X86MOV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define X86MOV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/x86mov_pkg.sv
// Types, opcode constants and length logic for the 8086 MOV decoder.
// No dependencies; imported by every other file of the block but the assertion header.
`default_nettype none

package x86mov_pkg;

	localparam int MAX_INSTR_BYTES = 6;
	localparam int CNT_W           = $clog2(MAX_INSTR_BYTES + 1);
	localparam int LEN_W           = 3;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [5:0] OPC_RM_REG  = 6'b100010;
	localparam logic [6:0] OPC_IMM_RM  = 7'b1100011;
	localparam logic [3:0] OPC_IMM_REG = 4'b1011;
	localparam logic [6:0] OPC_MEM_ACC = 7'b1010000;
	localparam logic [6:0] OPC_ACC_MEM = 7'b1010001;

	localparam logic [1:0] MOD_MEM    = 2'd0;
	localparam logic [1:0] MOD_DISP8  = 2'd1;
	localparam logic [1:0] MOD_DISP16 = 2'd2;
	localparam logic [2:0] RM_DIRECT  = 3'd6;

	typedef enum logic [2:0] {
		FORM_RM_REG  = 3'd0,
		FORM_IMM_RM  = 3'd1,
		FORM_IMM_REG = 3'd2,
		FORM_MEM_ACC = 3'd3,
		FORM_ACC_MEM = 3'd4,
		FORM_UNKNOWN = 3'd5
	} form_t;

	// One complete instruction as it leaves the byte assembler.
	typedef struct packed {
		logic [MAX_INSTR_BYTES-1:0][7:0] bytes;
		logic [LEN_W-1:0]                len;
	} raw_instr_t;

	// Number of displacement bytes that follow the mod-reg-r/m byte.
	function automatic logic [1:0] disp_bytes(input logic [1:0] md, input logic [2:0] rm);
		logic [1:0] n;
		n = 2'd0;
		case (md)
			MOD_MEM:    n = (rm == RM_DIRECT) ? 2'd2 : 2'd0;
			MOD_DISP8:  n = 2'd1;
			MOD_DISP16: n = 2'd2;
			default:    n = 2'd0;
		endcase
		return n;
	endfunction

	// Instruction length, or zero while the mod-reg-r/m byte is still missing.
	function automatic logic [LEN_W-1:0] instr_length(input logic [7:0] op,
			input logic [7:0] modrm, input logic have_modrm);
		logic [LEN_W-1:0] n;
		n = LEN_W'(1);
		if (op[7:2] == OPC_RM_REG || op[7:1] == OPC_IMM_RM) begin
			if (!have_modrm) begin
				n = '0;
			end else begin
				n = LEN_W'(2) + LEN_W'(disp_bytes(modrm[7:6], modrm[2:0]));
				if (op[7:1] == OPC_IMM_RM)
					n = n + LEN_W'(1) + LEN_W'(op[0]);
			end
		end else if (op[7:4] == OPC_IMM_REG) begin
			n = LEN_W'(2) + LEN_W'(op[3]);
		end else if (op[7:1] == OPC_MEM_ACC || op[7:1] == OPC_ACC_MEM) begin
			n = LEN_W'(3);
		end
		return n;
	endfunction

endpackage

`default_nettype wire

FILE: sv/x86mov_ifs.sv
// Valid/ready channel interfaces: raw code bytes in, decoded records out.
// Depends on x86mov_pkg for the form type.
`default_nettype none

interface x86mov_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;

	modport source (output valid, output code_byte, input ready);
	modport sink   (input valid, input code_byte, output ready);
endinterface

interface x86mov_rec_if import x86mov_pkg::*; ();
	logic               valid;
	logic               ready;
	form_t              form;
	logic               to_reg;
	logic               wide;
	logic [1:0]         mode;
	logic [2:0]         reg_sel;
	logic [2:0]         rm_sel;
	logic               direct_addr;
	logic signed [15:0] displacement;
	logic [15:0]        immediate;
	logic [2:0]         length;

	modport source (output valid, output form, output to_reg, output wide, output mode,
		output reg_sel, output rm_sel, output direct_addr, output displacement,
		output immediate, output length, input ready);
	modport sink (input valid, input form, input to_reg, input wide, input mode,
		input reg_sel, input rm_sel, input direct_addr, input displacement,
		input immediate, input length, output ready);
endinterface

`default_nettype wire

FILE: sv/x86mov_front.sv
// Byte assembler: buffers instruction bytes, finds the length, pushes whole instructions.
// Depends on x86mov_pkg, x86mov_ifs and the assertion header.
`default_nettype none
`include "x86_mov_instruction_decoder_core_assert.svh"

module x86mov_front import x86mov_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	x86mov_byte_if.sink  in_ch,
	input  wire logic    q_ready,
	output logic         push,
	output raw_instr_t   push_rec
);

	logic [7:0]       bytes_q [MAX_INSTR_BYTES];
	logic [CNT_W-1:0] count_q;

	logic [CNT_W-1:0] new_count;
	logic [LEN_W-1:0] len;
	logic             accept;
	logic             complete;

	assign in_ch.ready = q_ready;
	assign accept      = in_ch.valid && in_ch.ready;
	assign new_count   = count_q + CNT_W'(1);

	// Merge the arriving byte into the buffered view.
	always_comb begin
		for (int i = 0; i < MAX_INSTR_BYTES; i++)
			push_rec.bytes[i] = (count_q == CNT_W'(i)) ? in_ch.code_byte : bytes_q[i];
		len = instr_length(push_rec.bytes[0], push_rec.bytes[1],
			new_count >= CNT_W'(2));
		push_rec.len = len;
	end

	assign complete = (len != '0) && (new_count >= CNT_W'(len));
	assign push     = accept && complete;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= complete ? '0 : new_count;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < MAX_INSTR_BYTES; i++)
				if (count_q == CNT_W'(i))
					bytes_q[i] <= in_ch.code_byte;
		end
	end

	`X86MOV_ASSERT_NOW(a_count_range, 1'b1, count_q < CNT_W'(MAX_INSTR_BYTES),
		"byte count ran past the longest instruction")
	`X86MOV_ASSERT_NOW(a_push_len, push, push_rec.len != '0 &&
		push_rec.len <= LEN_W'(MAX_INSTR_BYTES), "pushed instruction with bad length")
	`X86MOV_ASSERT_NEXT(a_push_clears, push, count_q == '0,
		"buffer not emptied after a complete instruction")

endmodule

`default_nettype wire

FILE: sv/x86mov_queue.sv
// Two-entry queue of whole instructions between the assembler and the decoder.
// Depends on x86mov_pkg and the assertion header.
`default_nettype none
`include "x86_mov_instruction_decoder_core_assert.svh"

module x86mov_queue import x86mov_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire raw_instr_t  push_rec,
	output logic             not_full,
	input  wire logic        pop,
	output logic             not_empty,
	output raw_instr_t       head_rec
);

	raw_instr_t         entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign not_full  = count_q != Q_CNT_W'(Q_DEPTH);
	assign not_empty = count_q != '0;
	assign head_rec  = entry_q[rd_ptr_q];

	function automatic logic [Q_PTR_W-1:0] ptr_next(input logic [Q_PTR_W-1:0] p);
		return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + Q_CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - Q_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_rec;
	end

	`X86MOV_ASSERT_NOW(a_no_overflow, push, not_full || pop, "push into a full queue")
	`X86MOV_ASSERT_NOW(a_no_underflow, pop, not_empty, "pop from an empty queue")
	`X86MOV_ASSERT_NEXT(a_push_lands, push && !pop, not_empty,
		"queue empty right after a push")

endmodule

`default_nettype wire

FILE: sv/x86mov_back.sv
// Field decoder and output register: turns a whole instruction into a MOV record.
// Depends on x86mov_pkg, x86mov_ifs and the assertion header.
`default_nettype none
`include "x86_mov_instruction_decoder_core_assert.svh"

module x86mov_back import x86mov_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        deq_valid,
	input  wire raw_instr_t  deq_rec,
	output logic             deq_ready,
	x86mov_rec_if.source     out_ch
);

	logic               valid_q;
	form_t              form_q;
	logic               to_reg_q;
	logic               wide_q;
	logic [1:0]         mode_q;
	logic [2:0]         reg_sel_q;
	logic [2:0]         rm_sel_q;
	logic               direct_q;
	logic signed [15:0] disp_q;
	logic [15:0]        imm_q;
	logic [LEN_W-1:0]   len_q;

	form_t              form_d;
	logic               to_reg_d;
	logic               wide_d;
	logic [1:0]         mode_d;
	logic [2:0]         reg_sel_d;
	logic [2:0]         rm_sel_d;
	logic               direct_d;
	logic signed [15:0] disp_d;
	logic [15:0]        imm_d;
	logic [LEN_W-1:0]   len_d;

	logic [7:0] op;
	logic [7:0] m;
	logic [1:0] nd;
	logic [7:0] imm_lo;
	logic [7:0] imm_hi;

	assign op = deq_rec.bytes[0];
	assign m  = deq_rec.bytes[1];
	assign nd = disp_bytes(m[7:6], m[2:0]);

	// Immediate of the r/m form sits right after the displacement.
	always_comb begin
		case (nd)
			2'd0:    begin imm_lo = deq_rec.bytes[2]; imm_hi = deq_rec.bytes[3]; end
			2'd1:    begin imm_lo = deq_rec.bytes[3]; imm_hi = deq_rec.bytes[4]; end
			default: begin imm_lo = deq_rec.bytes[4]; imm_hi = deq_rec.bytes[5]; end
		endcase
	end

	always_comb begin
		form_d    = FORM_UNKNOWN;
		to_reg_d  = 1'b0;
		wide_d    = 1'b0;
		mode_d    = '0;
		reg_sel_d = '0;
		rm_sel_d  = '0;
		direct_d  = 1'b0;
		disp_d    = '0;
		imm_d     = '0;
		len_d     = deq_rec.len;
		if (op[7:2] == OPC_RM_REG || op[7:1] == OPC_IMM_RM) begin
			form_d    = (op[7:1] == OPC_IMM_RM) ? FORM_IMM_RM : FORM_RM_REG;
			to_reg_d  = (op[7:1] == OPC_IMM_RM) ? 1'b0 : op[1];
			wide_d    = op[0];
			mode_d    = m[7:6];
			reg_sel_d = m[5:3];
			rm_sel_d  = m[2:0];
			direct_d  = (m[7:6] == MOD_MEM) && (m[2:0] == RM_DIRECT);
			if (nd == 2'd2)
				disp_d = {deq_rec.bytes[3], deq_rec.bytes[2]};
			else if (nd == 2'd1)
				disp_d = {{8{deq_rec.bytes[2][7]}}, deq_rec.bytes[2]};
			if (op[7:1] == OPC_IMM_RM)
				imm_d = op[0] ? {imm_hi, imm_lo} : {8'h00, imm_lo};
		end else if (op[7:4] == OPC_IMM_REG) begin
			form_d    = FORM_IMM_REG;
			wide_d    = op[3];
			reg_sel_d = op[2:0];
			imm_d     = op[3] ? {deq_rec.bytes[2], deq_rec.bytes[1]}
				: {8'h00, deq_rec.bytes[1]};
		end else if (op[7:1] == OPC_MEM_ACC || op[7:1] == OPC_ACC_MEM) begin
			form_d = (op[7:1] == OPC_MEM_ACC) ? FORM_MEM_ACC : FORM_ACC_MEM;
			wide_d = op[0];
			disp_d = {deq_rec.bytes[2], deq_rec.bytes[1]};
		end else begin
			len_d = LEN_W'(1);
		end
	end

	// Load a new record when the output register is empty or being drained.
	assign deq_ready = !valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (deq_ready) begin
			valid_q <= deq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (deq_ready && deq_valid) begin
			form_q    <= form_d;
			to_reg_q  <= to_reg_d;
			wide_q    <= wide_d;
			mode_q    <= mode_d;
			reg_sel_q <= reg_sel_d;
			rm_sel_q  <= rm_sel_d;
			direct_q  <= direct_d;
			disp_q    <= disp_d;
			imm_q     <= imm_d;
			len_q     <= len_d;
		end
	end

	assign out_ch.valid        = valid_q;
	assign out_ch.form         = form_q;
	assign out_ch.to_reg       = to_reg_q;
	assign out_ch.wide         = wide_q;
	assign out_ch.mode         = mode_q;
	assign out_ch.reg_sel      = reg_sel_q;
	assign out_ch.rm_sel       = rm_sel_q;
	assign out_ch.direct_addr  = direct_q;
	assign out_ch.displacement = disp_q;
	assign out_ch.immediate    = imm_q;
	assign out_ch.length       = len_q;

	`X86MOV_ASSERT_NOW(a_unknown_len, valid_q && form_q == FORM_UNKNOWN, len_q == LEN_W'(1),
		"unknown opcode record with length other than one")
	`X86MOV_ASSERT_NOW(a_direct_mode, valid_q && direct_q, mode_q == MOD_MEM &&
		rm_sel_q == RM_DIRECT, "direct address flag without mod 0 and r/m 6")
	`X86MOV_ASSERT_NOW(a_imm_reg_len, valid_q && form_q == FORM_IMM_REG,
		len_q == LEN_W'(2) + LEN_W'(wide_q), "immediate-to-register length off")

endmodule

`default_nettype wire

FILE: sv/x86_mov_instruction_decoder_core.sv
// 8086 MOV instruction decoder.
//
// in_ch carries one raw code byte per transfer (valid/ready). Bytes are
// buffered until the instruction is complete; its length follows from the
// opcode and, for the r/m forms, the mod and r/m fields of the second byte.
// out_ch then carries one decoded record per instruction: form, d and w,
// mod/reg/r/m, direct-address flag, displacement, immediate and length.
// An opcode that is not a MOV form gives a one-byte record of form unknown.
// Throughput: one byte per cycle while the queue has room; the assembler
// finishes an instruction in the cycle its last byte transfers.
// With an idle output, a finished instruction is written into the queue and
// then loaded into the output register that drives out_ch.
// When the receiver stalls, the output register holds its record and the
// queue absorbs up to two more instructions; after that in_ch.ready drops
// until out_ch drains.
// Reset clears the byte count, the queue and the output valid; the decoder
// is ready for an opcode byte as soon as reset is released.
// Depends on x86mov_pkg, x86mov_ifs, x86mov_front, x86mov_queue, x86mov_back.
`default_nettype none

module x86_mov_instruction_decoder_core import x86mov_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	x86mov_byte_if.sink  in_ch,
	x86mov_rec_if.source out_ch
);

	logic       push;
	raw_instr_t push_rec;
	logic       q_not_full;
	logic       pop;
	logic       back_ready;
	logic       q_not_empty;
	raw_instr_t head_rec;

	// Pop only on an actual transfer into the back end.
	assign pop = back_ready && q_not_empty;

	x86mov_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.q_ready  (q_not_full),
		.push     (push),
		.push_rec (push_rec)
	);

	x86mov_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (push_rec),
		.not_full  (q_not_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head_rec  (head_rec)
	);

	x86mov_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.deq_valid (q_not_empty),
		.deq_rec   (head_rec),
		.deq_ready (back_ready),
		.out_ch    (out_ch)
	);

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking bench for the 8086 MOV decoder: streams code bytes over in_ch
// and checks every decoded record on out_ch against an in-bench decode.
// Depends on x86mov_pkg, x86mov_ifs and x86_mov_instruction_decoder_core.
`timescale 1ns / 100ps

module tb_top;
	import x86mov_pkg::*;

	localparam int unsigned STIM_BYTES  = 2000;
	localparam int unsigned LIMIT       = 400000;
	localparam int unsigned HOLD_CYCLES = 120;
	localparam int unsigned HOLD_AT     = 400;
	localparam int unsigned CALM_FROM   = 1000;
	localparam int unsigned CALM_TO     = 1400;
	localparam int unsigned IDLE_PCT    = 27;

	typedef struct packed {
		form_t       form;
		logic        to_reg;
		logic        wide;
		logic [1:0]  mode;
		logic [2:0]  reg_sel;
		logic [2:0]  rm_sel;
		logic        direct_addr;
		logic [15:0] displacement;
		logic [15:0] immediate;
		logic [2:0]  length;
	} mov_rec_t;

	logic clk = 1'b0;
	logic arst_n;

	x86mov_byte_if in_ch();
	x86mov_rec_if  out_ch();

	x86_mov_instruction_decoder_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	logic [7:0]  code_q[$];
	mov_rec_t    decoded_q[$];
	logic [7:0]  ibuf[MAX_INSTR_BYTES] = '{default: 8'h00};
	int unsigned ibuf_cnt    = 0;
	int unsigned bytes_total = 0;
	int unsigned bytes_in    = 0;
	int unsigned recs_seen   = 0;
	int unsigned err_count   = 0;
	int unsigned cycles      = 0;
	int unsigned form_seen[6] = '{default: 0};
	int unsigned holdoff;
	bit          holdoff_done;
	wire         calm = (bytes_in >= CALM_FROM) && (bytes_in < CALM_TO);

	function automatic bit is_modrm_op(input logic [7:0] op);
		return op[7:2] == OPC_RM_REG || op[7:1] == OPC_IMM_RM;
	endfunction

	function automatic bit is_mov_op(input logic [7:0] op);
		return is_modrm_op(op) || op[7:4] == OPC_IMM_REG ||
			op[7:1] == OPC_MEM_ACC || op[7:1] == OPC_ACC_MEM;
	endfunction

	function automatic int unsigned disp_len(input logic [1:0] md, input logic [2:0] rm);
		case (md)
			MOD_MEM:    return (rm == RM_DIRECT) ? 2 : 0;
			MOD_DISP8:  return 1;
			MOD_DISP16: return 2;
			default:    return 0;
		endcase
	endfunction

	// Length of the buffered instruction; zero while the mod-reg-r/m byte is missing.
	function automatic int unsigned pending_len();
		logic [7:0] op;
		op = ibuf[0];
		if (is_modrm_op(op)) begin
			if (ibuf_cnt < 2)
				return 0;
			return 2 + disp_len(ibuf[1][7:6], ibuf[1][2:0]) +
				((op[7:1] == OPC_IMM_RM) ? 1 + op[0] : 0);
		end
		if (op[7:4] == OPC_IMM_REG)
			return 2 + op[3];
		if (op[7:1] == OPC_MEM_ACC || op[7:1] == OPC_ACC_MEM)
			return 3;
		return 1;
	endfunction

	function automatic logic [15:0] word_from(input int unsigned pos);
		if (pos + 1 >= MAX_INSTR_BYTES)
			return '0;
		return {ibuf[pos + 1], ibuf[pos]};
	endfunction

	function automatic logic [7:0] byte_from(input int unsigned pos);
		if (pos >= MAX_INSTR_BYTES)
			return '0;
		return ibuf[pos];
	endfunction

	// Buffer one transferred byte; queue the decoded record once the instruction is whole.
	task automatic assemble_byte(input logic [7:0] b);
		mov_rec_t    r;
		logic [7:0]  op;
		logic [7:0]  m;
		logic [7:0]  d8;
		int unsigned ilen;
		int unsigned nd;
		if (ibuf_cnt >= MAX_INSTR_BYTES)
			ibuf_cnt = 0;
		ibuf[ibuf_cnt] = b;
		ibuf_cnt++;
		ilen = pending_len();
		if (ilen == 0 || ibuf_cnt < ilen)
			return;
		r = '0;
		op = ibuf[0];
		r.length = 3'(ilen);
		if (is_modrm_op(op)) begin
			m = ibuf[1];
			nd = disp_len(m[7:6], m[2:0]);
			r.form = (op[7:1] == OPC_IMM_RM) ? FORM_IMM_RM : FORM_RM_REG;
			r.to_reg = (r.form == FORM_RM_REG) ? op[1] : 1'b0;
			r.wide = op[0];
			r.mode = m[7:6];
			r.reg_sel = m[5:3];
			r.rm_sel = m[2:0];
			r.direct_addr = (m[7:6] == MOD_MEM) && (m[2:0] == RM_DIRECT);
			if (nd == 2) begin
				r.displacement = word_from(2);
			end else if (nd == 1) begin
				d8 = byte_from(2);
				r.displacement = {{8{d8[7]}}, d8};
			end
			if (r.form == FORM_IMM_RM)
				r.immediate = op[0] ? word_from(2 + nd) : {8'h00, byte_from(2 + nd)};
		end else if (op[7:4] == OPC_IMM_REG) begin
			r.form = FORM_IMM_REG;
			r.wide = op[3];
			r.reg_sel = op[2:0];
			r.immediate = op[3] ? word_from(1) : {8'h00, byte_from(1)};
		end else if (op[7:1] == OPC_MEM_ACC || op[7:1] == OPC_ACC_MEM) begin
			r.form = (op[7:1] == OPC_MEM_ACC) ? FORM_MEM_ACC : FORM_ACC_MEM;
			r.wide = op[0];
			r.displacement = word_from(1);
		end else begin
			r.form = FORM_UNKNOWN;
			r.length = 3'd1;
		end
		decoded_q = {decoded_q, r};
		ibuf_cnt = 0;
	endtask

	task automatic report_mismatch(input string msg);
		if (err_count < 50)
			$display("MISMATCH @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	task automatic check_record();
		mov_rec_t r;
		if (decoded_q.size() == 0) begin
			report_mismatch("record with no completed instruction behind it");
			return;
		end
		r = decoded_q.pop_front();
		form_seen[r.form]++;
		if (out_ch.form !== r.form)
			report_mismatch($sformatf("rec %0d form %0d, want %0d", recs_seen, out_ch.form, r.form));
		if (out_ch.to_reg !== r.to_reg)
			report_mismatch($sformatf("rec %0d to_reg %b, want %b", recs_seen, out_ch.to_reg, r.to_reg));
		if (out_ch.wide !== r.wide)
			report_mismatch($sformatf("rec %0d wide %b, want %b", recs_seen, out_ch.wide, r.wide));
		if (out_ch.mode !== r.mode)
			report_mismatch($sformatf("rec %0d mode %0d, want %0d", recs_seen, out_ch.mode, r.mode));
		if (out_ch.reg_sel !== r.reg_sel)
			report_mismatch($sformatf("rec %0d reg_sel %0d, want %0d", recs_seen, out_ch.reg_sel,
				r.reg_sel));
		if (out_ch.rm_sel !== r.rm_sel)
			report_mismatch($sformatf("rec %0d rm_sel %0d, want %0d", recs_seen, out_ch.rm_sel,
				r.rm_sel));
		if (out_ch.direct_addr !== r.direct_addr)
			report_mismatch($sformatf("rec %0d direct_addr %b, want %b", recs_seen,
				out_ch.direct_addr, r.direct_addr));
		if (out_ch.displacement !== r.displacement)
			report_mismatch($sformatf("rec %0d displacement %h, want %h", recs_seen,
				out_ch.displacement, r.displacement));
		if (out_ch.immediate !== r.immediate)
			report_mismatch($sformatf("rec %0d immediate %h, want %h", recs_seen,
				out_ch.immediate, r.immediate));
		if (out_ch.length !== r.length)
			report_mismatch($sformatf("rec %0d length %0d, want %0d", recs_seen, out_ch.length,
				r.length));
		recs_seen++;
	endtask

	task automatic push_code(input logic [7:0] b);
		code_q = {code_q, b};
		bytes_total++;
	endtask

	// Data byte, biased toward the sign and range edges.
	function automatic logic [7:0] data_byte();
		logic [7:0] edges[4];
		edges = '{8'h00, 8'h7F, 8'h80, 8'hFF};
		if ($urandom_range(3) == 0)
			return edges[$urandom_range(3)];
		return 8'($urandom_range(255));
	endfunction

	task automatic queue_instr();
		logic [7:0]  op;
		logic [7:0]  m;
		int unsigned nd;
		form_t       f;
		f = form_t'($urandom_range(FORM_UNKNOWN));
		case (f)
			FORM_RM_REG, FORM_IMM_RM: begin
				if (f == FORM_RM_REG)
					op = {OPC_RM_REG, 2'($urandom_range(3))};
				else
					op = {OPC_IMM_RM, 1'($urandom_range(1))};
				m = {2'($urandom_range(3)), 3'($urandom_range(7)), 3'($urandom_range(7))};
				if ($urandom_range(3) == 0)
					m[2:0] = RM_DIRECT;
				nd = disp_len(m[7:6], m[2:0]);
				push_code(op);
				push_code(m);
				repeat (nd) push_code(data_byte());
				if (f == FORM_IMM_RM)
					repeat (1 + op[0]) push_code(data_byte());
			end
			FORM_IMM_REG: begin
				op = {OPC_IMM_REG, 4'($urandom_range(15))};
				push_code(op);
				repeat (1 + op[3]) push_code(data_byte());
			end
			FORM_MEM_ACC, FORM_ACC_MEM: begin
				op = (f == FORM_MEM_ACC) ? {OPC_MEM_ACC, 1'($urandom_range(1))} :
					{OPC_ACC_MEM, 1'($urandom_range(1))};
				push_code(op);
				push_code(data_byte());
				push_code(data_byte());
			end
			default: begin
				do
					op = 8'($urandom_range(255));
				while (is_mov_op(op));
				push_code(op);
			end
		endcase
	endtask

	// Byte source: hold each byte until its transfer, then advance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.code_byte <= 8'h00;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				assemble_byte(in_ch.code_byte);
				bytes_in++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (code_q.size() != 0 &&
						(calm || holdoff != 0 || $urandom_range(99) >= IDLE_PCT)) begin
					in_ch.valid <= 1'b1;
					in_ch.code_byte <= code_q.pop_front();
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Record sink with random stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready)
				check_record();
			out_ch.ready <= (holdoff == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
		end
	end

	// One long output stall so the decoder queue fills and backs up into in_ch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff <= 0;
			holdoff_done <= 1'b0;
		end else if (!holdoff_done && bytes_in >= HOLD_AT) begin
			holdoff <= HOLD_CYCLES;
			holdoff_done <= 1'b1;
		end else if (holdoff != 0) begin
			holdoff <= holdoff - 1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Timeout after %0d cycles, %0d records outstanding", cycles,
				decoded_q.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.code_byte = 8'h00;
		out_ch.ready = 1'b0;

		// Directed: stream edges, every form, disp8 sign, direct address, mod 3
		// immediate, and 16-bit accumulator address with w clear.
		push_code(8'h00);
		push_code({OPC_RM_REG, 1'b0, 1'b0});
		push_code({MOD_MEM, 3'd7, RM_DIRECT});
		push_code(8'h34);
		push_code(8'h12);
		push_code({OPC_RM_REG, 1'b0, 1'b1});
		push_code({MOD_DISP8, 3'd0, 3'd7});
		push_code(8'h80);
		push_code({OPC_IMM_RM, 1'b1});
		push_code({MOD_DISP16, 3'd0, 3'd0});
		push_code(8'hFF);
		push_code(8'h7F);
		push_code(8'hFF);
		push_code(8'hFF);
		push_code({OPC_IMM_RM, 1'b0});
		push_code(8'hFF);
		push_code(8'h80);
		push_code({OPC_IMM_REG, 1'b1, 3'd7});
		push_code(8'hFF);
		push_code(8'hFF);
		push_code({OPC_MEM_ACC, 1'b0});
		push_code(8'h34);
		push_code(8'h12);
		push_code({OPC_ACC_MEM, 1'b1});
		push_code(8'h00);
		push_code(8'h80);
		push_code(8'hFF);

		// Mostly whole instructions, with stray bytes that split and merge them.
		while (bytes_total < STIM_BYTES) begin
			if ($urandom_range(99) < 15)
				repeat ($urandom_range(1, 4)) push_code(8'($urandom_range(255)));
			else
				queue_instr();
		end

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (bytes_in != bytes_total) @(posedge clk);
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		$display("Sent %0d code bytes, checked %0d records (rm-reg %0d, imm-rm %0d, imm-reg %0d,",
			bytes_in, recs_seen, form_seen[FORM_RM_REG], form_seen[FORM_IMM_RM],
			form_seen[FORM_IMM_REG]);
		$display("  mem-acc %0d, acc-mem %0d, unknown %0d), one %0d-cycle output stall",
			form_seen[FORM_MEM_ACC], form_seen[FORM_ACC_MEM], form_seen[FORM_UNKNOWN],
			HOLD_CYCLES);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
